@@ rtl/psg_pkg.sv @@
// Shared types and constants for the parallel schedule generator.
package psg_pkg;

  localparam int MAX_ACT       = 32;
  localparam int MAX_RES       = 4;
  localparam int PROFILE_DEPTH = 256;
  localparam int ACT_W         = 5;
  localparam int TIME_W        = 14;
  localparam int PROF_AW       = 8;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_EDGE = 2'd1;
  localparam logic [1:0] CMD_RUN  = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_DEADLOCK = 2'd1;
  localparam logic [1:0] STATUS_OVERCAP  = 2'd2;

  localparam logic [2:0] REG_ACT_COUNT = 3'd0;
  localparam logic [2:0] REG_RES_COUNT = 3'd1;
  localparam logic [2:0] REG_CAP_ZERO  = 3'd2;
  localparam logic [2:0] REG_CAP_ONE   = 3'd3;
  localparam logic [2:0] REG_CAP_TWO   = 3'd4;
  localparam logic [2:0] REG_CAP_THREE = 3'd5;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_INIT,
    OP_NEXT,
    OP_PINC,
    OP_START,
    OP_RDONE,
    OP_WRITE,
    OP_DEADLOCK,
    OP_AINIT,
    OP_AMIN,
    OP_ADONE,
    OP_ATIME,
    OP_CZERO,
    OP_OLOAD,
    OP_OACK
  } dp_op_t;

  typedef struct packed {
    logic cursor_end;
    logic cand_ok;
    logic per_end;
    logic fit_fail;
    logic all_started;
    logic none_active;
    logic load_err;
    logic out_last;
  } dp_stat_t;

endpackage

@@ rtl/psg_datapath.sv @@
// Datapath: activity stores, flags, free-capacity profile memory and result register.
module psg_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [7:0]            cfg_data,
  input  logic                  in_accept,
  input  logic [1:0]            in_command,
  input  logic [4:0]            in_activity,
  input  logic [7:0]            in_duration,
  input  logic [7:0]            in_demand_zero,
  input  logic [7:0]            in_demand_one,
  input  logic [7:0]            in_demand_two,
  input  logic [7:0]            in_demand_three,
  input  logic [4:0]            in_successor,
  input  psg_pkg::dp_op_t       op,
  output psg_pkg::dp_stat_t     stat,
  output logic                  out_valid,
  output logic [4:0]            out_scheduled_activity,
  output logic [13:0]           out_start_time,
  output logic [13:0]           out_makespan,
  output logic [1:0]            out_status,
  output logic                  out_last
);
  import psg_pkg::*;

  logic [4:0]          act_cnt_r;
  logic [2:0]          res_cnt_r;
  logic [7:0]          cap_r [MAX_RES];
  logic [MAX_ACT-1:0]  pred_r [MAX_ACT];
  logic [7:0]          dur_r [MAX_ACT];
  logic [31:0]         dem_r [MAX_ACT];
  logic [TIME_W-1:0]   start_r [MAX_ACT];
  logic [MAX_ACT-1:0]  pend_r, actv_r, done_r;
  logic [TIME_W-1:0]   time_r;
  logic [PROF_AW-1:0]  len_r, base_r, per_r;
  logic [5:0]          cursor_r;
  logic [TIME_W:0]     tmin_r;
  logic [1:0]          status_r;
  logic                load_err_r;
  logic                out_valid_r, out_last_r;
  logic [4:0]          out_act_r;
  logic [13:0]         out_start_r, out_mksp_r;

  logic [31:0]         prof_mem [PROFILE_DEPTH];
  logic [31:0]         prof_rd_r;
  logic [PROF_AW-1:0]  prof_addr;
  logic [31:0]         prof_wdata;
  logic                prof_we;

  logic [4:0]          n_real;
  logic [2:0]          rc;
  logic [5:0]          total;
  logic [MAX_ACT-1:0]  all_mask;
  logic [4:0]          idx;
  logic [7:0]          dur_c;
  logic [TIME_W:0]     fin_c;
  logic [TIME_W:0]     delta;
  logic                in_prof;
  logic                fail;
  logic [7:0]          avail [MAX_RES];
  logic [7:0]          dem_c [MAX_RES];
  logic [7:0]          in_dem [MAX_RES];
  logic                over;

  assign n_real = (act_cnt_r > 5'd30) ? 5'd30 : act_cnt_r;
  assign rc     = (res_cnt_r > 3'(MAX_RES)) ? 3'(MAX_RES) : res_cnt_r;
  assign total  = {1'b0, n_real} + 6'd2;
  assign idx    = cursor_r[4:0];
  assign dur_c  = dur_r[idx];
  assign fin_c  = {1'b0, start_r[idx]} + {7'd0, dur_c};
  assign delta  = tmin_r - {1'b0, time_r};
  assign in_prof = per_r < len_r;
  assign in_dem[0] = in_demand_zero;
  assign in_dem[1] = in_demand_one;
  assign in_dem[2] = in_demand_two;
  assign in_dem[3] = in_demand_three;

  always_comb begin
    for (int i = 0; i < MAX_ACT; i++) all_mask[i] = 6'(i) < total;
  end

  always_comb begin
    fail = 1'b0;
    over = 1'b0;
    for (int k = 0; k < MAX_RES; k++) begin
      dem_c[k] = dem_r[idx][8*k +: 8];
      avail[k] = in_prof ? prof_rd_r[8*k +: 8] : cap_r[k];
      if (3'(k) < rc && avail[k] < dem_c[k]) fail = 1'b1;
      if (3'(k) < rc && in_dem[k] > cap_r[k]) over = 1'b1;
      prof_wdata[8*k +: 8] = (3'(k) < rc) ? avail[k] - dem_c[k] : avail[k];
    end
  end

  assign prof_addr = base_r + per_r;
  assign prof_we   = (op == OP_WRITE);

  always_ff @(posedge clk) begin
    if (prof_we) prof_mem[prof_addr] <= prof_wdata;
    prof_rd_r <= prof_mem[prof_addr];
  end

  assign stat.cursor_end  = cursor_r >= total;
  assign stat.cand_ok     = pend_r[idx] && ((pred_r[idx] & all_mask & ~done_r) == '0);
  assign stat.per_end     = per_r >= dur_c;
  assign stat.fit_fail    = fail;
  assign stat.all_started = ((actv_r | done_r) & all_mask) == all_mask;
  assign stat.none_active = actv_r == '0;
  assign stat.load_err    = load_err_r;
  assign stat.out_last    = out_last_r;

  // Stores with no defined reset are written without clearing.
  always_ff @(posedge clk) begin
    if (in_accept && in_command == CMD_LOAD) begin
      dur_r[in_activity] <= in_duration;
      dem_r[in_activity] <= {in_demand_three, in_demand_two, in_demand_one, in_demand_zero};
    end
    if (op == OP_START) start_r[idx] <= time_r;
    if (op == OP_INIT) start_r[0] <= '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_cnt_r   <= 5'd30;
      res_cnt_r   <= 3'd4;
      for (int k = 0; k < MAX_RES; k++) cap_r[k] <= '0;
      for (int i = 0; i < MAX_ACT; i++) pred_r[i] <= '0;
      pend_r      <= '0;
      actv_r      <= '0;
      done_r      <= '0;
      time_r      <= '0;
      len_r       <= '0;
      base_r      <= '0;
      per_r       <= '0;
      cursor_r    <= '0;
      tmin_r      <= '0;
      status_r    <= STATUS_OK;
      load_err_r  <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      out_act_r   <= '0;
      out_start_r <= '0;
      out_mksp_r  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ACT_COUNT: act_cnt_r <= cfg_data[4:0];
          REG_RES_COUNT: res_cnt_r <= cfg_data[2:0];
          REG_CAP_ZERO:  cap_r[0]  <= cfg_data;
          REG_CAP_ONE:   cap_r[1]  <= cfg_data;
          REG_CAP_TWO:   cap_r[2]  <= cfg_data;
          REG_CAP_THREE: cap_r[3]  <= cfg_data;
          default: ;
        endcase
      end
      if (in_accept && in_command == CMD_LOAD && over) load_err_r <= 1'b1;
      if (in_accept && in_command == CMD_EDGE)
        pred_r[in_successor][in_activity] <= 1'b1;

      unique case (op)
        OP_INIT: begin
          actv_r   <= '0;
          time_r   <= '0;
          len_r    <= '0;
          base_r   <= '0;
          per_r    <= '0;
          cursor_r <= 6'd1;
          if (load_err_r) begin
            pend_r   <= '0;
            done_r   <= '0;
            status_r <= STATUS_OVERCAP;
          end else begin
            pend_r   <= all_mask & ~MAX_ACT'(1);
            done_r   <= MAX_ACT'(1);
            status_r <= STATUS_OK;
          end
        end
        OP_NEXT: begin
          cursor_r <= cursor_r + 6'd1;
          per_r    <= '0;
        end
        OP_PINC: per_r <= per_r + 8'd1;
        OP_START: begin
          pend_r[idx] <= 1'b0;
          actv_r[idx] <= 1'b1;
          per_r       <= '0;
        end
        OP_RDONE: begin
          if (dur_c > len_r) len_r <= dur_c;
          cursor_r <= cursor_r + 6'd1;
          per_r    <= '0;
        end
        OP_WRITE: per_r <= per_r + 8'd1;
        OP_DEADLOCK: begin
          status_r <= STATUS_DEADLOCK;
          cursor_r <= '0;
        end
        OP_AINIT: begin
          cursor_r <= '0;
          tmin_r   <= '1;
        end
        OP_AMIN: begin
          if (actv_r[idx] && fin_c < tmin_r) tmin_r <= fin_c;
          cursor_r <= cursor_r + 6'd1;
        end
        OP_ADONE: begin
          if (actv_r[idx] && fin_c == tmin_r) begin
            actv_r[idx] <= 1'b0;
            done_r[idx] <= 1'b1;
          end
          cursor_r <= cursor_r + 6'd1;
        end
        OP_ATIME: begin
          // slide the profile window forward to the new time
          if (delta >= {7'd0, len_r}) begin
            len_r <= '0;
          end else begin
            base_r <= base_r + delta[PROF_AW-1:0];
            len_r  <= len_r - delta[PROF_AW-1:0];
          end
          time_r   <= tmin_r[TIME_W-1:0];
          cursor_r <= 6'd1;
          per_r    <= '0;
        end
        OP_CZERO: cursor_r <= '0;
        OP_OLOAD: begin
          out_valid_r <= 1'b1;
          out_act_r   <= idx;
          out_start_r <= (actv_r[idx] | done_r[idx]) ? start_r[idx] : '0;
          out_last_r  <= (cursor_r + 6'd1) == total;
          out_mksp_r  <= ((cursor_r + 6'd1) == total) ? time_r : '0;
        end
        OP_OACK: begin
          out_valid_r <= 1'b0;
          cursor_r    <= cursor_r + 6'd1;
        end
        default: ;
      endcase
    end
  end

  assign out_valid              = out_valid_r;
  assign out_scheduled_activity = out_act_r;
  assign out_start_time         = out_start_r;
  assign out_makespan           = out_mksp_r;
  assign out_status             = status_r;
  assign out_last               = out_last_r;

endmodule

@@ rtl/psg_ctrl.sv @@
// Controller: sequences load, schedule search, time advance and result beats.
module psg_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_command,
  output logic               in_ready,
  input  logic               out_ready,
  input  psg_pkg::dp_stat_t  stat,
  output psg_pkg::dp_op_t    op
);
  import psg_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_INIT  = 14'b00000000000010,
    S_SCAN  = 14'b00000000000100,
    S_FREAD = 14'b00000000001000,
    S_FCMP  = 14'b00000000010000,
    S_START = 14'b00000000100000,
    S_RREAD = 14'b00000001000000,
    S_RWR   = 14'b00000010000000,
    S_CHECK = 14'b00000100000000,
    S_AMIN  = 14'b00001000000000,
    S_ADONE = 14'b00010000000000,
    S_OUT0  = 14'b00100000000000,
    S_EMIT  = 14'b01000000000000,
    S_OWAIT = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    unique case (state_r)
      S_IDLE:  if (in_valid && in_command == CMD_RUN) state_nxt = S_INIT;
      S_INIT: begin
        op        = OP_INIT;
        state_nxt = stat.load_err ? S_OUT0 : S_SCAN;
      end
      S_SCAN: begin
        if (stat.cursor_end) state_nxt = S_CHECK;
        else if (stat.cand_ok) state_nxt = S_FREAD;
        else op = OP_NEXT;
      end
      S_FREAD: state_nxt = stat.per_end ? S_START : S_FCMP;
      S_FCMP: begin
        if (stat.fit_fail) begin
          op        = OP_NEXT;
          state_nxt = S_SCAN;
        end else begin
          op        = OP_PINC;
          state_nxt = S_FREAD;
        end
      end
      S_START: begin
        op        = OP_START;
        state_nxt = S_RREAD;
      end
      S_RREAD: begin
        if (stat.per_end) begin
          op        = OP_RDONE;
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_RWR;
        end
      end
      S_RWR: begin
        op        = OP_WRITE;
        state_nxt = S_RREAD;
      end
      S_CHECK: begin
        if (stat.all_started) begin
          state_nxt = S_OUT0;
        end else if (stat.none_active) begin
          op        = OP_DEADLOCK;
          state_nxt = S_EMIT;
        end else begin
          op        = OP_AINIT;
          state_nxt = S_AMIN;
        end
      end
      S_AMIN: begin
        if (stat.cursor_end) begin
          op        = OP_CZERO;
          state_nxt = S_ADONE;
        end else begin
          op = OP_AMIN;
        end
      end
      S_ADONE: begin
        if (stat.cursor_end) begin
          op        = OP_ATIME;
          state_nxt = S_SCAN;
        end else begin
          op = OP_ADONE;
        end
      end
      S_OUT0: begin
        op        = OP_CZERO;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        op        = OP_OLOAD;
        state_nxt = S_OWAIT;
      end
      S_OWAIT: begin
        if (out_ready) begin
          op        = OP_OACK;
          state_nxt = stat.out_last ? S_IDLE : S_EMIT;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

@@ rtl/parallel_schedule_generator.sv @@
// Parallel schedule generator: resource-constrained list scheduling over up to 30 activities.
// Load and edge beats are taken while the controller is idle. A run walks the activities in
// index order: a candidate whose predecessors are done is checked against the free-capacity
// profile period by period, and a start then reserves capacity period by period, both bound
// by the single port of the 256-entry profile memory. Each time advance takes two passes over
// the activities. Results then leave one beat at a time, each held until the consumer is
// ready. No new beat is taken until the last result is delivered.
module parallel_schedule_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [4:0]  in_activity,
  input  logic [7:0]  in_duration,
  input  logic [7:0]  in_demand_zero,
  input  logic [7:0]  in_demand_one,
  input  logic [7:0]  in_demand_two,
  input  logic [7:0]  in_demand_three,
  input  logic [4:0]  in_successor,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_scheduled_activity,
  output logic [13:0] out_start_time,
  output logic [13:0] out_makespan,
  output logic [1:0]  out_status,
  output logic        out_last
);
  import psg_pkg::*;

  dp_op_t   op;
  dp_stat_t stat;
  logic     in_accept;

  assign in_accept = in_valid && in_ready;

  psg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_ready   (in_ready),
    .out_ready  (out_ready),
    .stat       (stat),
    .op         (op)
  );

  psg_datapath u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .in_accept              (in_accept),
    .in_command             (in_command),
    .in_activity            (in_activity),
    .in_duration            (in_duration),
    .in_demand_zero         (in_demand_zero),
    .in_demand_one          (in_demand_one),
    .in_demand_two          (in_demand_two),
    .in_demand_three        (in_demand_three),
    .in_successor           (in_successor),
    .op                     (op),
    .stat                   (stat),
    .out_valid              (out_valid),
    .out_scheduled_activity (out_scheduled_activity),
    .out_start_time         (out_start_time),
    .out_makespan           (out_makespan),
    .out_status             (out_status),
    .out_last               (out_last)
  );

`ifndef SYNTHESIS
  a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while a result beat is pending");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> in_ready) else $error("not idle after last beat");

  a_overcap_zero_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_OVERCAP |-> out_start_time == '0 && out_makespan == '0)
    else $error("over-capacity run reports nonzero times");
`endif

endmodule
